@@ hdl/kged_pkg.sv @@
// shared types, constants and helpers of the key gesture event detector
// used by kged_ctrl, kged_dp and key_gesture_event_detector
package kged_pkg;

    localparam int KEYS = 4;
    localparam int KW   = 2;     // key index width
    localparam int MW   = 4 * KEYS;  // one event slot per timer per key
    localparam int PW   = $clog2(MW);

    localparam logic [2:0] EV_PRESS     = 3'd0;
    localparam logic [2:0] EV_RELEASE   = 3'd1;
    localparam logic [2:0] EV_SINGLE    = 3'd2;
    localparam logic [2:0] EV_TRIPLE    = 3'd4;
    localparam logic [2:0] EV_LONG      = 3'd5;
    localparam logic [2:0] EV_LONG_LONG = 3'd6;
    localparam logic [2:0] EV_CONT      = 3'd7;

    localparam logic [2:0] CFG_ENABLE    = 3'd0;
    localparam logic [2:0] CFG_CLICK_GAP = 3'd1;
    localparam logic [2:0] CFG_LONG      = 3'd2;
    localparam logic [2:0] CFG_LONG_LONG = 3'd3;
    localparam logic [2:0] CFG_REPEAT    = 3'd4;

    localparam logic [1:0] KIND_TRIPLE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic tick_start;
        logic key_apply;
        logic scan_step;
        logic emit_en;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic pending;
    } t_stat;

    // a delay written as zero counts as 1 ms
    function automatic logic [15:0] delay_of(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

@@ hdl/kged_ctrl.sv @@
// sequencer of the key gesture event detector: idle, timer scan, event emission
// depends on kged_pkg
module kged_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_req_type,
    input  kged_pkg::t_stat i_stat,
    output logic          o_in_ready,
    output kged_pkg::t_cmd  o_cmd
);
    import kged_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_req_type ? ST_SCAN : ST_EMIT;
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_stat.pending) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.tick_start = i_in_valid && i_req_type;
                o_cmd.key_apply  = i_in_valid && !i_req_type;
            end
            ST_SCAN: o_cmd.scan_step = 1'b1;
            ST_EMIT: o_cmd.emit_en   = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && !i_stat.scan_last) |=> r_state == ST_SCAN)
        else $error("scan left early");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && i_stat.pending) |=> r_state == ST_EMIT)
        else $error("emission dropped pending events");

endmodule

@@ hdl/kged_dp.sv @@
// datapath: configuration, per-key timers and tallies, event queue and output register
// depends on kged_pkg
module kged_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  kged_pkg::t_cmd          i_cmd,
    output kged_pkg::t_stat         o_stat,
    input  logic [kged_pkg::KW-1:0] i_key_index,
    input  logic                    i_pressed,
    input  logic                    i_cfg_valid,
    input  logic [2:0]              i_cfg_index,
    input  logic [31:0]             i_cfg_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_key_index_res,
    output logic [2:0]              o_event_code,
    output logic                    o_last_result
);
    import kged_pkg::*;

    logic [31:0] r_enable;
    logic [15:0] r_gap, r_long, r_long_long, r_repeat;
    logic [31:0] r_now;

    logic [2:0]  r_tally   [KEYS];
    logic [31:0] r_pstamp  [KEYS];
    logic [31:0] r_rstamp  [KEYS];
    logic [15:0] r_cw      [KEYS];
    logic [1:0]  r_kind    [KEYS];
    logic [15:0] r_lw      [KEYS];
    logic [15:0] r_llw     [KEYS];
    logic [15:0] r_rw      [KEYS];
    logic [1:0]  r_ev_kind [KEYS];  // click kind seen at scan, read at emission

    logic [KW-1:0] r_kidx;
    logic [MW-1:0] r_mask;
    logic          r_kev_valid;
    logic [KW-1:0] r_kev_key;
    logic [2:0]    r_kev_code;

    logic          r_out_valid;
    logic [1:0]    r_out_key;
    logic [2:0]    r_out_code;
    logic          r_out_last;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 32'd0;
            r_gap       <= 16'd500;
            r_long      <= 16'd1500;
            r_long_long <= 16'd5000;
            r_repeat    <= 16'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENABLE:    r_enable    <= i_cfg_data;
                CFG_CLICK_GAP: r_gap       <= i_cfg_data[15:0];
                CFG_LONG:      r_long      <= i_cfg_data[15:0];
                CFG_LONG_LONG: r_long_long <= i_cfg_data[15:0];
                CFG_REPEAT:    r_repeat    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // one key served per cycle, the scanned one or the changed one
    logic [KW-1:0] sel;
    logic [7:0]    en;
    logic [2:0]    tally;
    logic [31:0]   pstamp, rstamp;
    logic [15:0]   cw, lw, llw, rw;
    logic [1:0]    kind, kc;
    logic          en_click;

    assign sel    = i_cmd.scan_step ? r_kidx : i_key_index;
    assign en     = r_enable[8*sel +: 8];
    assign tally  = r_tally[sel];
    assign pstamp = r_pstamp[sel];
    assign rstamp = r_rstamp[sel];
    assign cw     = r_cw[sel];
    assign lw     = r_lw[sel];
    assign llw    = r_llw[sel];
    assign rw     = r_rw[sel];
    assign kind   = r_kind[sel];
    assign kc     = (kind > KIND_TRIPLE) ? KIND_TRIPLE : kind;
    assign en_click = en[EV_SINGLE + {1'b0, kc}];

    // tick path
    logic        ev_click, ev_long, ev_ll, ev_cont;
    logic [15:0] cw_t, lw_t, llw_t, rw_t;

    always_comb begin
        ev_click = (cw == 16'd1) && en_click;
        ev_long  = (lw == 16'd1) && en[EV_LONG];
        ev_ll    = (llw == 16'd1) && en[EV_LONG_LONG];
        ev_cont  = (rw == 16'd1) && en[EV_CONT];
        cw_t  = (cw != 16'd0) ? cw - 16'd1 : 16'd0;
        lw_t  = (lw != 16'd0) ? lw - 16'd1 : 16'd0;
        llw_t = (llw != 16'd0) ? llw - 16'd1 : 16'd0;
        rw_t  = (rw != 16'd0) ? rw - 16'd1 : 16'd0;
        if ((ev_long && en[EV_CONT]) || ev_cont) begin
            rw_t = delay_of(r_repeat);
        end
    end

    // level change path
    logic        kev_en;
    logic [2:0]  kev_code;
    logic [2:0]  tally_k;
    logic [15:0] cw_k, lw_k, llw_k, rw_k;
    logic [1:0]  kind_k, new_kind;
    logic        cancel_ok;

    always_comb begin
        cw_k     = cw;
        lw_k     = lw;
        llw_k    = llw;
        rw_k     = rw;
        kind_k   = kind;
        tally_k  = tally;
        new_kind = 2'd0;
        cancel_ok = (cw != 16'd0) && en_click;
        if (i_pressed) begin
            kev_code = EV_PRESS;
            if (en[EV_LONG])      lw_k  = delay_of(r_long);
            if (en[EV_LONG_LONG]) llw_k = delay_of(r_long_long);
            if ((r_now - rstamp) >= {16'd0, r_gap}) begin
                tally_k = 3'd1;
            end else if (tally < 3'd4) begin
                tally_k = tally + 3'd1;
            end
            if (cancel_ok) cw_k = 16'd0;
        end else begin
            kev_code = EV_RELEASE;
            if (en[EV_LONG])      lw_k  = 16'd0;
            if (en[EV_LONG_LONG]) llw_k = 16'd0;
            if (en[EV_CONT])      rw_k  = 16'd0;
            if ((r_now - pstamp) >= {16'd0, r_long}) tally_k = 3'd0;
            if (tally_k >= 3'd1 && tally_k <= 3'd3) begin
                new_kind = tally_k[1:0] - 2'd1;
                if (cancel_ok) cw_k = 16'd0;
                if (en[EV_SINGLE + {1'b0, new_kind}]) begin
                    kind_k = new_kind;
                    cw_k   = delay_of(r_gap);
                end
            end else if (tally_k > 3'd3) begin
                if (cw != 16'd0 && kind == KIND_TRIPLE && en[EV_TRIPLE]) cw_k = 16'd0;
            end
        end
        kev_en = en[kev_code];
    end

    logic key_ok;
    assign key_ok = i_cmd.key_apply && (int'(i_key_index) < KEYS);

    // per-key state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEYS; k++) begin
                r_tally[k]  <= 3'd0;
                r_pstamp[k] <= 32'd0;
                r_rstamp[k] <= 32'd0;
                r_cw[k]     <= 16'd0;
                r_kind[k]   <= 2'd0;
                r_lw[k]     <= 16'd0;
                r_llw[k]    <= 16'd0;
                r_rw[k]     <= 16'd0;
            end
        end else if (i_cmd.scan_step) begin
            r_cw[sel]  <= cw_t;
            r_lw[sel]  <= lw_t;
            r_llw[sel] <= llw_t;
            r_rw[sel]  <= rw_t;
        end else if (key_ok) begin
            r_cw[sel]    <= cw_k;
            r_lw[sel]    <= lw_k;
            r_llw[sel]   <= llw_k;
            r_rw[sel]    <= rw_k;
            r_kind[sel]  <= kind_k;
            r_tally[sel] <= tally_k;
            if (i_pressed) begin
                r_pstamp[sel] <= r_now;
            end else begin
                r_rstamp[sel] <= r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_ev_kind[sel] <= kc;
        end
    end

    // emission picks the lowest pending slot: key ascending, then timer order
    logic [PW-1:0] pos;
    logic [MW-1:0] mask_rest;
    logic          load;
    logic [2:0]    slot_code;

    always_comb begin
        pos = '0;
        for (int i = MW - 1; i >= 0; i--) begin
            if (r_mask[i]) pos = PW'(i);
        end
        mask_rest = r_mask & (r_mask - MW'(1));
        unique case (pos[1:0])
            2'd0:    slot_code = EV_SINGLE + {1'b0, r_ev_kind[pos[PW-1:2]]};
            2'd1:    slot_code = EV_LONG;
            2'd2:    slot_code = EV_LONG_LONG;
            default: slot_code = EV_CONT;
        endcase
    end

    assign load = i_cmd.emit_en && (!r_out_valid || i_out_ready)
                  && (r_kev_valid || (r_mask != '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now       <= 32'd0;
            r_kidx      <= '0;
            r_mask      <= '0;
            r_kev_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.tick_start) begin
                r_now  <= r_now + 32'd1;
                r_kidx <= '0;
                r_mask <= '0;
            end else if (i_cmd.scan_step) begin
                r_kidx <= r_kidx + KW'(1);
                r_mask[4*sel +: 4] <= {ev_cont, ev_ll, ev_long, ev_click};
            end else if (load && !r_kev_valid) begin
                r_mask <= mask_rest;
            end
            if (key_ok) begin
                r_kev_valid <= kev_en;
            end else if (load) begin
                r_kev_valid <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_ok) begin
            r_kev_key  <= i_key_index;
            r_kev_code <= kev_code;
        end
        if (load) begin
            if (r_kev_valid) begin
                r_out_key  <= r_kev_key;
                r_out_code <= r_kev_code;
                r_out_last <= 1'b1;
            end else begin
                r_out_key  <= pos[PW-1:2];
                r_out_code <= slot_code;
                r_out_last <= (mask_rest == '0);
            end
        end
    end

    assign o_stat.scan_last = (r_kidx == KW'(KEYS - 1));
    assign o_stat.pending   = r_kev_valid || (r_mask != '0);
    assign o_out_valid      = r_out_valid;
    assign o_key_index_res  = r_out_key;
    assign o_event_code     = r_out_code;
    assign o_last_result    = r_out_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_kev_valid && (r_mask != '0)))
        else $error("key event and timer events pending together");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick_start |=> (r_mask == '0))
        else $error("event queue not cleared at tick");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=>
            (r_out_valid && $stable(r_out_key) && $stable(r_out_code)))
        else $error("output overwritten while stalled");

endmodule

@@ hdl/key_gesture_event_detector.sv @@
// level change: accepted in idle; its event, if enabled, then goes to the output register and the block returns to idle
// tick: accepted in idle, then a timer scan of all KEYS keys (one key per cycle), then its events are emitted
// (up to 4 per key), held back while the output is stalled; one request at a time
// the output register lets the next request in while the last event is still waiting
// synchronous active-low reset: counters, timers and tallies zero, registers at defaults
// top level; depends on kged_pkg, kged_ctrl, kged_dp
module key_gesture_event_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [1:0]  i_key_index,
    input  logic        i_pressed,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_key_index_res,
    output logic [2:0]  o_event_code,
    output logic        o_last_result
);
    import kged_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    kged_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    kged_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_key_index     (i_key_index),
        .i_pressed       (i_pressed),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_key_index_res (o_key_index_res),
        .o_event_code    (o_event_code),
        .o_last_result   (o_last_result)
    );

endmodule

@@ verif/key_gesture_event_detector_tb.sv @@
// self-checking testbench of the key gesture event detector: directed and random
// key level changes and ticks with a built-in event predictor; depends on kged_pkg
`timescale 1ns / 100ps

module key_gesture_event_detector_tb;
    import kged_pkg::*;

    localparam logic REQ_LEVEL = 1'b0;
    localparam logic REQ_TICK  = 1'b1;
    localparam int   IDLE_CYCLES_LIMIT = 20000;

    typedef struct packed {
        logic [1:0] key;
        logic [2:0] code;
        logic       last;
    } t_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_req_type = 1'b0;
    logic [1:0]  i_key_index = '0;
    logic        i_pressed = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_key_index_res;
    logic [2:0]  o_event_code;
    logic        o_last_result;

    key_gesture_event_detector DUT (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [31:0] en_mask;
    logic [15:0] gap_ms, long_ms, long_long_ms, rep_ms;
    logic [31:0] clock_ms;
    logic [2:0]  tally [KEYS];
    logic [31:0] down_at [KEYS];
    logic [31:0] up_at [KEYS];
    logic [15:0] click_cnt [KEYS];
    logic [1:0]  click_sel [KEYS];
    logic [15:0] long_cnt [KEYS];
    logic [15:0] long_long_cnt [KEYS];
    logic [15:0] rep_cnt [KEYS];

    t_event pending_events[$];
    t_event new_events[$];
    int     error_count = 0;
    int     event_count = 0;
    int     request_count = 0;
    bit     quiet_out = 1'b0;   // no receiver idling
    bit     hold_out = 1'b0;    // long receiver hold-off
    bit     quiet_in = 1'b0;

    function automatic bit ev_on(int k, logic [2:0] ev);
        return en_mask[8 * k + ev];
    endfunction

    function automatic logic [15:0] at_least_one(logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic logic [2:0] click_code(int k);
        return EV_SINGLE + ((click_sel[k] > 2'd2) ? 3'd2 : 3'(click_sel[k]));
    endfunction

    function automatic void note_event(int k, logic [2:0] ev);
        t_event e;
        if (new_events.size() >= MW)
            return;
        e.key = 2'(k);
        e.code = ev;
        e.last = 1'b0;
        new_events.push_back(e);
    endfunction

    function automatic void drop_click(int k);
        if (click_cnt[k] != 0 && ev_on(k, click_code(k)))
            click_cnt[k] = 0;
    endfunction

    function automatic bit step_down(ref logic [15:0] w);
        if (w == 0)
            return 1'b0;
        w = w - 1;
        return w == 0;
    endfunction

    function automatic void predict_reset();
        en_mask = 0;
        gap_ms = 16'd500;
        long_ms = 16'd1500;
        long_long_ms = 16'd5000;
        rep_ms = 16'd100;
        clock_ms = 0;
        for (int k = 0; k < KEYS; k++) begin
            tally[k] = 0;
            down_at[k] = 0;
            up_at[k] = 0;
            click_cnt[k] = 0;
            click_sel[k] = 0;
            long_cnt[k] = 0;
            long_long_cnt[k] = 0;
            rep_cnt[k] = 0;
        end
    endfunction

    function automatic void predict_level(int k, bit down);
        logic [31:0] gap;
        if (down) begin
            if (ev_on(k, EV_PRESS)) note_event(k, EV_PRESS);
            if (ev_on(k, EV_LONG)) long_cnt[k] = at_least_one(long_ms);
            if (ev_on(k, EV_LONG_LONG)) long_long_cnt[k] = at_least_one(long_long_ms);
            gap = clock_ms - up_at[k];
            if (gap >= {16'd0, gap_ms})
                tally[k] = 1;
            else if (tally[k] < 4)
                tally[k] = tally[k] + 1;
            down_at[k] = clock_ms;
            drop_click(k);
        end else begin
            if (ev_on(k, EV_RELEASE)) note_event(k, EV_RELEASE);
            if (ev_on(k, EV_LONG)) long_cnt[k] = 0;
            if (ev_on(k, EV_LONG_LONG)) long_long_cnt[k] = 0;
            if (ev_on(k, EV_CONT)) rep_cnt[k] = 0;
            gap = clock_ms - down_at[k];
            if (gap >= {16'd0, long_ms})
                tally[k] = 0;
            up_at[k] = clock_ms;
            if (tally[k] >= 1 && tally[k] <= 3) begin
                drop_click(k);
                if (ev_on(k, EV_SINGLE + 3'(tally[k] - 1))) begin
                    click_sel[k] = 2'(tally[k] - 1);
                    click_cnt[k] = at_least_one(gap_ms);
                end
            end else if (tally[k] > 3) begin
                if (click_cnt[k] != 0 && click_sel[k] == KIND_TRIPLE && ev_on(k, EV_TRIPLE))
                    click_cnt[k] = 0;
            end
        end
    endfunction

    function automatic void predict_tick();
        bit c, l, ll, r;
        clock_ms = clock_ms + 1;
        for (int k = 0; k < KEYS; k++) begin
            c = step_down(click_cnt[k]);
            l = step_down(long_cnt[k]);
            ll = step_down(long_long_cnt[k]);
            r = step_down(rep_cnt[k]);
            if (c && ev_on(k, click_code(k))) note_event(k, click_code(k));
            if (l && ev_on(k, EV_LONG)) begin
                if (ev_on(k, EV_CONT)) rep_cnt[k] = at_least_one(rep_ms);
                note_event(k, EV_LONG);
            end
            if (ll && ev_on(k, EV_LONG_LONG)) note_event(k, EV_LONG_LONG);
            if (r && ev_on(k, EV_CONT)) begin
                rep_cnt[k] = at_least_one(rep_ms);
                note_event(k, EV_CONT);
            end
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    task automatic send_request(input logic kind, input logic [1:0] key, input logic down);
        while (!quiet_in && $urandom_range(99) < 8)
            @(negedge i_clk);
        i_req_type <= kind;
        i_key_index <= key;
        i_pressed <= down;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        new_events.delete();
        if (kind == REQ_TICK)
            predict_tick();
        else
            predict_level(key, down);
        if (new_events.size() > 0)
            new_events[new_events.size() - 1].last = 1'b1;
        foreach (new_events[i])
            pending_events.push_back(new_events[i]);
        request_count++;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        // the block is busy for at least this cycle after an accept
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0)
            @(negedge i_clk);
        repeat (4 * KEYS + 8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_ENABLE:    en_mask = val;
            CFG_CLICK_GAP: gap_ms = val[15:0];
            CFG_LONG:      long_ms = val[15:0];
            CFG_LONG_LONG: long_long_ms = val[15:0];
            CFG_REPEAT:    rep_ms = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_all(input logic [31:0] en, input logic [15:0] gap,
                           input logic [15:0] lp, input logic [15:0] llp,
                           input logic [15:0] rp);
        wait_drained();
        write_reg(CFG_ENABLE, en);
        write_reg(CFG_CLICK_GAP, {16'd0, gap});
        write_reg(CFG_LONG, {16'd0, lp});
        write_reg(CFG_LONG_LONG, {16'd0, llp});
        write_reg(CFG_REPEAT, {16'd0, rp});
    endtask

    task automatic ticks(input int n);
        repeat (n) send_request(REQ_TICK, 2'($urandom_range(3)), 1'($urandom_range(1)));
    endtask

    // receiver
    always @(negedge i_clk) begin
        if (hold_out)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= quiet_out || ($urandom_range(99) >= 8);
    end

    always @(posedge i_clk) begin
        t_event want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            event_count++;
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("unexpected event key %0d code %0d",
                                          o_key_index_res, o_event_code));
            end else begin
                want = pending_events.pop_front();
                if (o_key_index_res !== want.key)
                    report_mismatch($sformatf("key %0d want %0d", o_key_index_res, want.key));
                if (o_event_code !== want.code)
                    report_mismatch($sformatf("code %0d want %0d", o_event_code, want.code));
                if (o_last_result !== want.last)
                    report_mismatch($sformatf("last %0d want %0d", o_last_result, want.last));
            end
        end
    end

    // watchdog on cycles with no request, event or register write
    int stall_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= IDLE_CYCLES_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_defaults();
        // all events off at reset: nothing comes out
        send_request(REQ_LEVEL, 2'd0, 1'b1);
        send_request(REQ_LEVEL, 2'd0, 1'b0);
        ticks(2);
    endtask

    task automatic test_clicks();
        set_all(32'hFFFF_FFFF, 16'd4, 16'd6, 16'd12, 16'd3);
        for (int n = 1; n <= 4; n++) begin
            repeat (n) begin
                send_request(REQ_LEVEL, 2'd3, 1'b1);
                send_request(REQ_LEVEL, 2'd3, 1'b0);
            end
            ticks(5);
        end
        // long, long-long and repeats, then zero delays
        send_request(REQ_LEVEL, 2'd1, 1'b1);
        ticks(14);
        send_request(REQ_LEVEL, 2'd1, 1'b0);
        set_all(32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0);
        for (int k = 0; k < KEYS; k++) send_request(REQ_LEVEL, 2'(k), 1'b1);
        ticks(3);
    endtask

    task automatic test_backpressure();
        set_all(32'hFFFF_FFFF, 16'd2, 16'd2, 16'd3, 16'd1);
        fork
            begin
                hold_out = 1'b1;
                repeat (300) @(negedge i_clk);
                hold_out = 1'b0;
            end
            ticks(8);
        join
        for (int k = 0; k < KEYS; k++) send_request(REQ_LEVEL, 2'(k), 1'b0);
    endtask

    task automatic test_random();
        logic [31:0] en;
        int key;
        for (int phase = 0; phase < 2; phase++) begin
            en = (phase == 0) ? 32'hFFFF_FFFF : $urandom;
            set_all(en, 16'($urandom_range(1, 8)), 16'($urandom_range(2, 15)),
                    16'($urandom_range(3, 25)), 16'($urandom_range(1, 4)));
            quiet_in = (phase == 1);
            quiet_out = (phase == 1);
            repeat (4) begin
                key = $urandom_range(3);
                if ($urandom_range(99) < 70) begin
                    // well-formed press, hold, release
                    send_request(REQ_LEVEL, 2'(key), 1'b1);
                    ticks($urandom_range(0, 6));
                    send_request(REQ_LEVEL, 2'(key), 1'b0);
                    ticks($urandom_range(0, 3));
                end else begin
                    send_request(1'($urandom_range(1)), 2'(key), 1'($urandom_range(1)));
                end
            end
            quiet_in = 1'b0;
            quiet_out = 1'b0;
        end
        // extreme delays, kept short by not waiting them out
        set_all(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(REQ_LEVEL, 2'd2, 1'b1);
        ticks(1);
        send_request(REQ_LEVEL, 2'd2, 1'b0);
        ticks(1);
    endtask

    initial begin
        predict_reset();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_defaults();
        test_clicks();
        test_backpressure();
        test_random();
        wait_drained();
        $display("covered %0d requests and %0d events: clicks, holds, repeats, stalls",
                 request_count, event_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ key_gesture_event_detector.f @@
hdl/kged_pkg.sv
hdl/kged_ctrl.sv
hdl/kged_dp.sv
hdl/key_gesture_event_detector.sv
verif/key_gesture_event_detector_tb.sv
